### rtl/pvts_pkg.sv
// shared widths, register indexes and step constants for the peep valve time stepper
`default_nettype none

package pvts_pkg;

    localparam int PRES_W = 8;
    localparam int TIME_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int CNT_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_PEEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BREATH_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_START = 2'd2;

    localparam logic [PRES_W-1:0] TARGET_RESET = 8'd5;
    localparam logic [PRES_W-1:0] RATE_RESET = 8'd15;
    localparam logic [PRES_W-1:0] OFFSET_RESET = 8'd3;

    localparam logic [PRES_W-1:0] HIGH_RATE = 8'd30;
    localparam logic [TIME_W-1:0] TIME_LIMIT = 16'd700;
    localparam logic [TIME_W-1:0] TIME_FLOOR = 16'd1;
    localparam logic [PRES_W-1:0] OFFSET_FLOOR = 8'd3;
    localparam logic [PRES_W-1:0] OFFSET_MAX = 8'd255;

    localparam logic [TIME_W-1:0] STEP_BIG_UP = 16'd100;
    localparam logic [TIME_W-1:0] STEP_MID_UP = 16'd40;
    localparam logic [TIME_W-1:0] STEP_SMALL = 16'd10;
    localparam logic [TIME_W-1:0] STEP_MID_DOWN = 16'd30;
    localparam logic [TIME_W-1:0] STEP_BIG_DOWN = 16'd50;

    localparam logic [PRES_W+1:0] BAND_WIDE = 10'd8;
    localparam logic [PRES_W+1:0] BAND_NARROW = 10'd2;

    // a hit counter acts on the third hit
    localparam logic [CNT_W-1:0] CNT_LAST = 2'd2;

endpackage

`default_nettype wire

### rtl/pvts_if.sv
// valid/ready channel interfaces for samples, results and configuration writes
`default_nettype none

interface pvts_sample_if;
    import pvts_pkg::*;
    logic              valid;
    logic              ready;
    logic [PRES_W-1:0] measured_peep;
    logic [PRES_W-1:0] peak_peep;
    logic [TIME_W-1:0] inspire_ms;
    logic [TIME_W-1:0] open_time_in;

    modport source (output valid, measured_peep, peak_peep, inspire_ms, open_time_in,
                    input ready);
    modport sink (input valid, measured_peep, peak_peep, inspire_ms, open_time_in,
                  output ready);
endinterface

interface pvts_result_if;
    import pvts_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] open_time;
    logic [PRES_W-1:0] peep_offset;

    modport source (output valid, open_time, peep_offset, input ready);
    modport sink (input valid, open_time, peep_offset, output ready);
endinterface

interface pvts_cfg_if;
    import pvts_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/peep_valve_time_stepper_top.sv
// Peep valve time stepper: one sample per cycle in while results drain, one result per
// sample out. A sample is taken into an input register, and the band decision, hit
// counting, clamping and offset update happen in the single pass from that register into
// the result register, so a new sample may be accepted every cycle unless the result
// register is stalled; each item reads and writes the offset and hit counters as it moves
// into the result register. Configuration writes are always taken; writing the offset
// start register also loads the offset at once.
`default_nettype none

module peep_valve_time_stepper_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pvts_cfg_if.sink      cfg,
    pvts_sample_if.sink   sample,
    pvts_result_if.source result
);
    import pvts_pkg::*;

    // configuration and state
    logic [PRES_W-1:0] target_reg;
    logic [PRES_W-1:0] rate_reg;
    logic [PRES_W-1:0] offset_reg, offset_next;
    logic [CNT_W-1:0]  fast_up_cnt_reg, fast_up_cnt_next;
    logic [CNT_W-1:0]  fast_down_cnt_reg, fast_down_cnt_next;

    // input register
    logic              s1_valid_reg;
    logic [PRES_W-1:0] s1_achieved_reg;
    logic [PRES_W-1:0] s1_peak_reg;
    logic [TIME_W-1:0] s1_inspire_reg;
    logic [TIME_W-1:0] s1_time_reg;

    // result register
    logic              out_valid_reg;
    logic [TIME_W-1:0] out_time_reg, out_time_next;
    logic [PRES_W-1:0] out_offset_reg;

    logic advance;
    logic take;
    logic cfg_wr;

    logic              high;
    logic [PRES_W-1:0] meas;
    logic [PRES_W+1:0] a_ext;
    logic [PRES_W+1:0] p_ext;
    logic              up_hit;
    logic              down_hit;
    logic              zero_hit;
    logic [TIME_W-1:0] up_step;
    logic [TIME_W-1:0] down_step;
    logic              acts;
    logic [TIME_W:0]   sum;
    logic              clamp;
    logic [TIME_W-1:0] diff;
    logic              floor_hit;
    logic [PRES_W-1:0] off_tmp;

    assign advance = s1_valid_reg && (!out_valid_reg || result.ready);
    assign take = sample.valid && sample.ready;
    assign cfg_wr = cfg.valid && cfg.ready;

    assign sample.ready = !s1_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign result.valid = out_valid_reg;
    assign result.open_time = out_time_reg;
    assign result.peep_offset = out_offset_reg;

    always_comb
    begin
        high = rate_reg >= HIGH_RATE;
        meas = (high && (s1_inspire_reg <= TIME_LIMIT)) ? s1_peak_reg : s1_achieved_reg;
        a_ext = {2'b00, meas};
        p_ext = {2'b00, target_reg};

        up_hit = 1'b0;
        down_hit = 1'b0;
        zero_hit = 1'b0;
        up_step = STEP_SMALL;
        down_step = STEP_SMALL;
        // lower bands written as a + k < p so no signed range is needed
        if (a_ext > p_ext + BAND_WIDE)
        begin
            up_hit = 1'b1;
            up_step = STEP_BIG_UP;
        end
        else if (a_ext > p_ext + BAND_NARROW)
        begin
            up_hit = 1'b1;
            up_step = STEP_MID_UP;
        end
        else if (a_ext > p_ext)
        begin
            up_hit = 1'b1;
        end
        else if (meas == '0)
        begin
            zero_hit = 1'b1;
        end
        else if (a_ext + BAND_WIDE < p_ext)
        begin
            down_hit = 1'b1;
            down_step = STEP_BIG_DOWN;
        end
        else if (a_ext + BAND_NARROW < p_ext)
        begin
            down_hit = 1'b1;
            down_step = STEP_MID_DOWN;
        end
        else if (a_ext < p_ext)
        begin
            down_hit = 1'b1;
        end

        fast_up_cnt_next = fast_up_cnt_reg;
        fast_down_cnt_next = fast_down_cnt_reg;
        acts = 1'b0;
        if (up_hit)
        begin
            if (!high)
            begin
                acts = 1'b1;
            end
            else if (fast_up_cnt_reg == CNT_LAST)
            begin
                acts = 1'b1;
                fast_up_cnt_next = '0;
            end
            else
            begin
                fast_up_cnt_next = fast_up_cnt_reg + 1'b1;
            end
        end
        else if (down_hit || zero_hit)
        begin
            if (!high)
            begin
                acts = 1'b1;
            end
            else if (fast_down_cnt_reg == CNT_LAST)
            begin
                acts = 1'b1;
                fast_down_cnt_next = '0;
            end
            else
            begin
                fast_down_cnt_next = fast_down_cnt_reg + 1'b1;
            end
        end

        sum = {1'b0, s1_time_reg} + {1'b0, up_step};
        clamp = high ? (sum > {1'b0, TIME_LIMIT}) : (sum >= {1'b0, TIME_LIMIT});
        diff = s1_time_reg - down_step;
        floor_hit = (diff == '0) || (diff > TIME_LIMIT);

        out_time_next = s1_time_reg;
        off_tmp = offset_reg;
        if (up_hit)
        begin
            if (acts)
            begin
                if (clamp)
                begin
                    out_time_next = TIME_LIMIT;
                    if (offset_reg != '0)
                    begin
                        off_tmp = offset_reg - 1'b1;
                    end
                end
                else
                begin
                    out_time_next = sum[TIME_W-1:0];
                end
            end
            if (off_tmp <= OFFSET_FLOOR)
            begin
                off_tmp = OFFSET_FLOOR;
            end
        end
        else if (acts)
        begin
            out_time_next = floor_hit ? TIME_FLOOR : diff;
            // a zero reading raises the offset unless it is at its maximum, other down bands only on the floor
            if ((zero_hit || floor_hit) && (offset_reg != OFFSET_MAX))
            begin
                off_tmp = offset_reg + 1'b1;
            end
        end
        offset_next = off_tmp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            rate_reg <= RATE_RESET;
            offset_reg <= OFFSET_RESET;
            fast_up_cnt_reg <= '0;
            fast_down_cnt_reg <= '0;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg.index)
                    REG_TARGET_PEEP:  target_reg <= cfg.data;
                    REG_BREATH_RATE:  rate_reg <= cfg.data;
                    REG_OFFSET_START: offset_reg <= cfg.data;
                    default:          ;
                endcase
            end
            else if (advance)
            begin
                offset_reg <= offset_next;
            end

            if (advance)
            begin
                fast_up_cnt_reg <= fast_up_cnt_next;
                fast_down_cnt_reg <= fast_down_cnt_next;
            end

            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_achieved_reg <= sample.measured_peep;
            s1_peak_reg <= sample.peak_peep;
            s1_inspire_reg <= sample.inspire_ms;
            s1_time_reg <= sample.open_time_in;
        end
        if (advance)
        begin
            out_time_reg <= out_time_next;
            out_offset_reg <= offset_next;
        end
    end

    // hit counters wrap on the third hit and never hold three
    assert property (@(posedge clk) disable iff (!rst_n)
        (fast_up_cnt_reg != 2'd3) && (fast_down_cnt_reg != 2'd3))
    else $error("hit counter out of range");

    // a pending item that cannot move stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
    else $error("input register lost an item");

    // a result taken while an item waits is replaced by that item
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result.ready && s1_valid_reg) |=> out_valid_reg)
    else $error("result register emptied with an item waiting");

    // an item in an upward band leaves the offset at or above its floor
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && up_hit && !cfg_wr) |=> (offset_reg >= OFFSET_FLOOR))
    else $error("offset below floor after upward step");

endmodule

`default_nettype wire

### test/peep_valve_time_stepper_top_test.sv
// self-checking testbench for the peep valve time stepper: bands, random breaths, backpressure
`default_nettype none

module peep_valve_time_stepper_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pvts_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PRES_W-1:0] achieved;
        logic [PRES_W-1:0] peak;
        logic [TIME_W-1:0] inspire;
        logic [TIME_W-1:0] open_in;
    } breath_t;

    typedef struct packed {
        logic [TIME_W-1:0] open_time;
        logic [PRES_W-1:0] peep_offset;
    } valve_result_t;

    logic clk = 1'b0;
    logic rst_n;

    pvts_cfg_if    cfg_ch ();
    pvts_sample_if sample_ch ();
    pvts_result_if result_ch ();

    peep_valve_time_stepper_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sample (sample_ch),
        .result (result_ch)
    );

    // predicted block state
    logic [PRES_W-1:0] set_target = TARGET_RESET;
    logic [PRES_W-1:0] set_rate = RATE_RESET;
    logic [PRES_W-1:0] offset_now = OFFSET_RESET;
    logic [CNT_W-1:0]  rise_hits = '0;
    logic [CNT_W-1:0]  fall_hits = '0;

    valve_result_t pending_results[$];
    int            mismatch_count = 0;
    int            result_seq = 0;
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    logic          hold_active = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic predict_valve_step(input breath_t b, output valve_result_t r);
        logic              fast;
        logic              acts;
        logic              zero_read;
        int                p;
        int                a;
        int                rise;
        int                fall;
        logic [31:0]       sum;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] diff;
        fast = (set_rate >= HIGH_RATE);
        // at high rate with a short inspiration the peak reading stands in
        a = (fast && b.inspire <= TIME_LIMIT) ? int'(b.peak) : int'(b.achieved);
        p = int'(set_target);
        t = b.open_in;
        rise = 0;
        fall = 0;
        zero_read = 1'b0;
        acts = 1'b0;
        if (a > p + int'(BAND_WIDE))
            rise = int'(STEP_BIG_UP);
        else if (a > p + int'(BAND_NARROW))
            rise = int'(STEP_MID_UP);
        else if (a > p)
            rise = int'(STEP_SMALL);
        else if (a == 0)
            zero_read = 1'b1;
        else if (a < p - int'(BAND_WIDE))
            fall = int'(STEP_BIG_DOWN);
        else if (a < p - int'(BAND_NARROW))
            fall = int'(STEP_MID_DOWN);
        else if (a < p)
            fall = int'(STEP_SMALL);

        if (rise != 0)
        begin
            if (!fast)
                acts = 1'b1;
            else if (rise_hits == CNT_LAST)
            begin
                rise_hits = '0;
                acts = 1'b1;
            end
            else
                rise_hits = rise_hits + 1'b1;
            if (acts)
            begin
                sum = {16'd0, t} + rise[31:0];
                if (fast ? (sum > {16'd0, TIME_LIMIT}) : (sum >= {16'd0, TIME_LIMIT}))
                begin
                    t = TIME_LIMIT;
                    if (offset_now != '0)
                        offset_now = offset_now - 1'b1;
                end
                else
                    t = sum[TIME_W-1:0];
            end
            if (offset_now <= OFFSET_FLOOR)
                offset_now = OFFSET_FLOOR;
        end
        else if (zero_read || fall != 0)
        begin
            if (!fast)
                acts = 1'b1;
            else if (fall_hits == CNT_LAST)
            begin
                fall_hits = '0;
                acts = 1'b1;
            end
            else
                fall_hits = fall_hits + 1'b1;
            if (acts)
            begin
                if (zero_read)
                    fall = int'(STEP_SMALL);
                diff = t - fall[TIME_W-1:0];
                if (zero_read && offset_now != OFFSET_MAX)
                    offset_now = offset_now + 1'b1;
                if (diff < TIME_FLOOR || diff > TIME_LIMIT)
                begin
                    t = TIME_FLOOR;
                    if (!zero_read && offset_now != OFFSET_MAX)
                        offset_now = offset_now + 1'b1;
                end
                else
                    t = diff;
            end
        end
        r.open_time = t;
        r.peep_offset = offset_now;
    endtask

    // valid stays high across back-to-back transactions
    task automatic send_breath(input breath_t b);
        valve_result_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.measured_peep <= b.achieved;
        sample_ch.peak_peep <= b.peak;
        sample_ch.inspire_ms <= b.inspire;
        sample_ch.open_time_in <= b.open_in;
        do @(posedge clk); while (!sample_ch.ready);
        predict_valve_step(b, r);
        pending_results.push_back(r);
    endtask

    task automatic send_fields(input int ach, input int pk, input int insp, input int otin);
        breath_t b;
        b.achieved = ach[PRES_W-1:0];
        b.peak = pk[PRES_W-1:0];
        b.inspire = insp[TIME_W-1:0];
        b.open_in = otin[TIME_W-1:0];
        send_breath(b);
    endtask

    task automatic settle_block();
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [PRES_W-1:0] value);
        settle_block();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_TARGET_PEEP:  set_target = value;
            REG_BREATH_RATE:  set_rate = value;
            REG_OFFSET_START: offset_now = value;
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            valve_result_t want;
            result_seq++;
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("result %0d arrived with nothing pending: open_time %0d peep_offset %0d",
                             result_seq, result_ch.open_time, result_ch.peep_offset);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.open_time !== want.open_time ||
                    result_ch.peep_offset !== want.peep_offset)
                begin
                    if (mismatch_count < 10)
                        $display("result %0d: expected open_time %0d peep_offset %0d, got %0d %0d",
                                 result_seq, want.open_time, want.peep_offset,
                                 result_ch.open_time, result_ch.peep_offset);
                    mismatch_count++;
                end
            end
        end
        result_ch.ready <= !hold_active && ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [PRES_W-1:0] rand_pressure(input logic [PRES_W-1:0] centre);
        int v;
        case ($urandom_range(9))
            0:       v = 0;
            1, 2:    v = $urandom_range(255);
            default: v = int'(centre) + $urandom_range(24) - 12;
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[PRES_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] rand_open_time();
        case ($urandom_range(9))
            0:       return TIME_W'($urandom_range(65535));
            1:       return TIME_W'($urandom_range(60));
            2, 3:    return TIME_W'(590 + $urandom_range(120));
            default: return TIME_W'($urandom_range(720));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] rand_inspire();
        case ($urandom_range(7))
            0, 1:    return TIME_W'($urandom_range(65535));
            2, 3:    return TIME_W'(690 + $urandom_range(20));
            default: return TIME_W'($urandom_range(1500));
        endcase
    endfunction

    function automatic logic [PRES_W-1:0] pick_target();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return PRES_W'($urandom_range(255));
            default: return PRES_W'(8 + $urandom_range(40));
        endcase
    endfunction

    function automatic logic [PRES_W-1:0] pick_rate();
        case ($urandom_range(6))
            0:       return 8'd0;
            1:       return 8'd29;
            2:       return 8'd30;
            3:       return 8'd255;
            4:       return PRES_W'($urandom_range(255));
            default: return PRES_W'($urandom_range(10, 60));
        endcase
    endfunction

    function automatic logic [PRES_W-1:0] pick_offset_start();
        case ($urandom_range(6))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd254;
            3, 4:    return PRES_W'($urandom_range(1, 5));
            default: return PRES_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_breath();
        breath_t b;
        b.achieved = rand_pressure(set_target);
        b.peak = rand_pressure(set_target);
        b.inspire = rand_inspire();
        b.open_in = rand_open_time();
        send_breath(b);
    endtask

    // reset configuration: target 5, low rate, offset 3
    task automatic test_reset_state();
        send_fields(0, 0, 0, 0);            // zero reading wraps below zero
        send_fields(5, 255, 65535, 65535);  // on target, passes through
        send_fields(255, 0, 0, 65535);      // big step clamps, offset floor
        send_fields(6, 0, 0, 690);          // reaching the limit clamps at low rate
        send_fields(8, 0, 0, 11);
        send_fields(1, 0, 0, 30);           // lands on zero, floors to one
        send_fields(4, 0, 0, 11);
        send_fields(3, 0, 0, 701);
    endtask

    task automatic test_band_edges();
        write_register(REG_TARGET_PEEP, 8'd20);
        write_register(REG_OFFSET_START, 8'd10);
        send_fields(11, 0, 0, 400);
        send_fields(12, 0, 0, 400);
        send_fields(17, 0, 0, 400);
        send_fields(18, 0, 0, 400);
        send_fields(19, 0, 0, 400);
        send_fields(21, 0, 0, 400);
        send_fields(22, 0, 0, 400);
        send_fields(23, 0, 0, 400);
        send_fields(28, 0, 0, 400);
        send_fields(29, 0, 0, 400);
    endtask

    task automatic test_high_rate();
        write_register(REG_BREATH_RATE, HIGH_RATE);
        // peak reading used; third hit lands exactly on the limit without clamping
        repeat (3) send_fields(20, 29, 700, 600);
        // long inspiration keeps the measured reading
        repeat (3) send_fields(0, 20, 701, 5);
    endtask

    task automatic test_offset_limits();
        write_register(REG_BREATH_RATE, 8'd0);
        write_register(REG_TARGET_PEEP, 8'd0);
        write_register(REG_OFFSET_START, 8'd255);
        repeat (2) send_fields(0, 0, 0, 300);   // increment saturates
        write_register(REG_OFFSET_START, 8'd0);
        send_fields(1, 0, 0, 65535);            // decrement saturates, then floor
        write_register(REG_UNUSED, 8'hAA);
        write_register(REG_TARGET_PEEP, 8'd255);
        send_fields(0, 255, 0, 9);
    endtask

    task automatic test_random_traffic();
        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 66; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 23; stall_pct = 23; end
            endcase
            for (int round = 0; round < 3; round++)
            begin
                write_register(REG_TARGET_PEEP, pick_target());
                write_register(REG_BREATH_RATE, pick_rate());
                write_register(REG_OFFSET_START, pick_offset_start());
                if ($urandom_range(3) == 0)
                    write_register(REG_UNUSED, PRES_W'($urandom_range(255)));
                repeat (55) send_random_breath();
            end
        end
    endtask

    // receiver holds off while the sender keeps offering transactions
    task automatic test_backpressure();
        write_register(REG_TARGET_PEEP, 8'd20);
        write_register(REG_BREATH_RATE, 8'd40);
        send_idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                hold_active <= 1'b1;
                repeat (150) @(posedge clk);
                hold_active <= 1'b0;
            end
            begin
                repeat (40) send_random_breath();
            end
        join
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.measured_peep = '0;
        sample_ch.peak_peep = '0;
        sample_ch.inspire_ms = '0;
        sample_ch.open_time_in = '0;
        result_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_band_edges();
        test_high_rate();
        test_offset_limits();
        test_random_traffic();
        test_backpressure();

        settle_block();
        repeat (10) @(posedge clk);
        mismatch_count += pending_results.size();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
